>>> rtl/core/nscc_pkg.sv
// ============================================================================
// nscc_pkg
// Shared types and constants for the NAL start code type counter.
// ============================================================================
package nscc_pkg;

  // Configuration register width and its value after reset.
  localparam int unsigned LIMIT_W        = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  // Default width of the saturating type counters.
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Reported width of each type count.
  localparam int unsigned REPORT_W = 32;

  // Byte window: the start code (four bytes) plus the type byte.
  localparam int unsigned WIN_BYTES = 5;
  localparam int unsigned WIN_W     = WIN_BYTES * 8;
  localparam int unsigned FILL_W    = 3;
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_BYTES);

  // Start code 00 00 00 01, oldest byte in the high bits.
  localparam logic [31:0] START_CODE = 32'h0000_0001;

  // NAL unit type field.
  localparam int unsigned   TYPE_W    = 5;
  localparam logic [7:0]    TYPE_MASK = 8'h1F;

  typedef enum logic [TYPE_W-1:0] {
    NAL_NON_IDR = 5'd1,
    NAL_IDR     = 5'd5,
    NAL_SPS     = 5'd7,
    NAL_PPS     = 5'd8
  } nal_type_t;

  // Input stream sideband bits.
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned TUSER_SEL   = 0;
  localparam int unsigned TUSER_FIRST = 1;

  // Result stream layout, lowest bit first.
  localparam int unsigned OUT_IDR_LSB     = 0;
  localparam int unsigned OUT_NON_IDR_LSB = 32;
  localparam int unsigned OUT_SPS_LSB     = 64;
  localparam int unsigned OUT_PPS_LSB     = 96;
  localparam int unsigned OUT_PKT_LSB     = 128;
  localparam int unsigned OUT_NO_IDR_BIT  = 144;
  localparam int unsigned OUT_LIMIT_BIT   = 145;
  localparam int unsigned OUT_USED_W      = 146;
  localparam int unsigned OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

endpackage

>>> rtl/core/nal_start_code_type_counter.sv
// ============================================================================
// nal_start_code_type_counter
// Scans packet bytes for Annex B start codes and counts IDR, non-IDR, SPS
// and PPS units, reporting the running totals at the end of each scanned packet.
// ============================================================================
//
//  Channel | Direction | Handshake               | Contents
//  --------+-----------+-------------------------+------------------------------
//  in_     | input     | in_tvalid / in_tready   | one packet byte per request
//  out_    | output    | out_tvalid / out_tready | running counts per packet
//  cfg_    | input     | cfg_valid / cfg_ready   | packet_limit
//
// One byte is accepted per clock unless a report waits on a low out_tready;
// a byte passes an input register and then the scan logic, and a packet's
// report enters the result register as its last byte leaves the input stage.
// The result register holds a report while out_tready is low; bytes that
// produce no report keep flowing, and only a report byte waits for it.
// Reset (rst_n low, synchronous) clears all counts and loads packet_limit
// with 100. cfg_ready is always high.
//
module nal_start_code_type_counter #(
  parameter int unsigned COUNT_WIDTH = nscc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Packet byte stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nscc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // last_of_packet
  input  logic [nscc_pkg::IN_TUSER_W-1:0]   in_tuser,   // [0] selected_stream,
                                                        // [1] first_of_file
  // Report stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nscc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [31:0] idr_count,
                                                        // [63:32] non_idr_count,
                                                        // [95:64] sps_count,
                                                        // [127:96] pps_count,
                                                        // [143:128] packets_counted,
                                                        // [144] no_idr,
                                                        // [145] limit_reached,
                                                        // [151:146] zero
  // Packet limit write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nscc_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Configuration register.
  logic [nscc_pkg::LIMIT_W-1:0] limit_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_sel_r;
  logic       s1_last_r;
  logic       s1_first_r;

  // Scan state.
  logic [nscc_pkg::WIN_W-1:0]   win_r,     win_nxt;
  logic [nscc_pkg::FILL_W-1:0]  fill_r,    fill_nxt;
  logic [COUNT_WIDTH-1:0]       idr_r,     idr_nxt;
  logic [COUNT_WIDTH-1:0]       non_idr_r, non_idr_nxt;
  logic [COUNT_WIDTH-1:0]       sps_r,     sps_nxt;
  logic [COUNT_WIDTH-1:0]       pps_r,     pps_nxt;
  logic [nscc_pkg::LIMIT_W-1:0] pkt_r,     pkt_nxt;

  // Result register.
  logic                             out_valid_r, out_valid_nxt;
  logic [nscc_pkg::OUT_TDATA_W-1:0] out_data_r,  out_data_nxt;

  // Values after an optional start-of-file clear.
  logic [nscc_pkg::WIN_W-1:0]   win_e;
  logic [nscc_pkg::FILL_W-1:0]  fill_e;
  logic [COUNT_WIDTH-1:0]       idr_e, non_idr_e, sps_e, pps_e;
  logic [nscc_pkg::LIMIT_W-1:0] pkt_e;

  logic                        scan;
  logic                        emit;
  logic                        s1_go;
  logic                        unit_found;
  logic [nscc_pkg::TYPE_W-1:0] nal_type;

  // Handshakes: the input stage moves on unless its report is blocked.
  assign emit      = s1_last_r && scan;
  assign s1_go     = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Start of file clears the counts before the byte is handled.
  always_comb begin
    win_e     = s1_first_r ? '0 : win_r;
    fill_e    = s1_first_r ? '0 : fill_r;
    idr_e     = s1_first_r ? '0 : idr_r;
    non_idr_e = s1_first_r ? '0 : non_idr_r;
    sps_e     = s1_first_r ? '0 : sps_r;
    pps_e     = s1_first_r ? '0 : pps_r;
    pkt_e     = s1_first_r ? '0 : pkt_r;
  end

  // Start code detection on the window before this byte enters it.
  assign scan       = s1_sel_r && (pkt_e < limit_r);
  assign unit_found = (fill_e >= nscc_pkg::FILL_FULL) &&
                      (win_e[nscc_pkg::WIN_W-1:8] == nscc_pkg::START_CODE);
  assign nal_type   = nscc_pkg::TYPE_W'(win_e[7:0] & nscc_pkg::TYPE_MASK);

  // Counter, window and report update.
  always_comb begin
    win_nxt       = win_e;
    fill_nxt      = fill_e;
    idr_nxt       = idr_e;
    non_idr_nxt   = non_idr_e;
    sps_nxt       = sps_e;
    pps_nxt       = pps_e;
    pkt_nxt       = pkt_e;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (scan) begin
      if (unit_found) begin
        case (nal_type)
          nscc_pkg::NAL_IDR: begin
            if (idr_e != COUNT_MAX) idr_nxt = idr_e + 1'b1;
          end
          nscc_pkg::NAL_NON_IDR: begin
            if (non_idr_e != COUNT_MAX) non_idr_nxt = non_idr_e + 1'b1;
          end
          nscc_pkg::NAL_SPS: begin
            if (sps_e != COUNT_MAX) sps_nxt = sps_e + 1'b1;
          end
          nscc_pkg::NAL_PPS: begin
            if (pps_e != COUNT_MAX) pps_nxt = pps_e + 1'b1;
          end
          default: begin
          end
        endcase
      end
      win_nxt = {win_e[nscc_pkg::WIN_W-9:0], s1_data_r};
      if (fill_e < nscc_pkg::FILL_FULL) fill_nxt = fill_e + 1'b1;

      if (s1_last_r) begin
        pkt_nxt = pkt_e + 1'b1;
        out_data_nxt = '0;
        out_data_nxt[nscc_pkg::OUT_IDR_LSB +: nscc_pkg::REPORT_W] =
          nscc_pkg::REPORT_W'(idr_nxt);
        out_data_nxt[nscc_pkg::OUT_NON_IDR_LSB +: nscc_pkg::REPORT_W] =
          nscc_pkg::REPORT_W'(non_idr_nxt);
        out_data_nxt[nscc_pkg::OUT_SPS_LSB +: nscc_pkg::REPORT_W] =
          nscc_pkg::REPORT_W'(sps_nxt);
        out_data_nxt[nscc_pkg::OUT_PPS_LSB +: nscc_pkg::REPORT_W] =
          nscc_pkg::REPORT_W'(pps_nxt);
        out_data_nxt[nscc_pkg::OUT_PKT_LSB +: nscc_pkg::LIMIT_W] = pkt_nxt;
        out_data_nxt[nscc_pkg::OUT_NO_IDR_BIT] = (idr_nxt == '0);
        out_data_nxt[nscc_pkg::OUT_LIMIT_BIT]  = (pkt_nxt == limit_r);
        out_valid_nxt = 1'b1;
      end
    end

    // The end of any packet empties the window.
    if (s1_last_r) begin
      win_nxt  = '0;
      fill_nxt = '0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= nscc_pkg::LIMIT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
      fill_r      <= '0;
      idr_r       <= '0;
      non_idr_r   <= '0;
      sps_r       <= '0;
      pps_r       <= '0;
      pkt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_go) begin
        out_valid_r <= out_valid_nxt;
        win_r       <= win_nxt;
        fill_r      <= fill_nxt;
        idr_r       <= idr_nxt;
        non_idr_r   <= non_idr_nxt;
        sps_r       <= sps_nxt;
        pps_r       <= pps_nxt;
        pkt_r       <= pkt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata;
      s1_sel_r   <= in_tuser[nscc_pkg::TUSER_SEL];
      s1_last_r  <= in_tlast;
      s1_first_r <= in_tuser[nscc_pkg::TUSER_FIRST];
    end
    if (s1_go) out_data_r <= out_data_nxt;
  end

endmodule

>>> rtl/core/nscc_checker.sv
// ============================================================================
// nscc_checker
// Port-level checks on the report stream of the start code type counter.
// ============================================================================
module nscc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [nscc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A report held by the sink stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("report changed while stalled");

  // The no-IDR flag is only set when the IDR count reads zero.
  a_no_idr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[nscc_pkg::OUT_NO_IDR_BIT] |->
      out_tdata[nscc_pkg::OUT_IDR_LSB +: nscc_pkg::REPORT_W] == '0)
    else $error("no_idr set with a nonzero IDR count");

  // Every report follows at least one scanned packet.
  a_pkt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[nscc_pkg::OUT_PKT_LSB +: nscc_pkg::LIMIT_W] != '0)
    else $error("report with zero packets counted");

  // Reset drops any pending report.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("report valid right after reset");

endmodule

bind nal_start_code_type_counter nscc_checker u_nscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
